// ----- hdl/grouped_free_block_allocator_macros.svh -----
// Assertion macros used by the verification file of the allocator.
`ifndef GROUPED_FREE_BLOCK_ALLOCATOR_MACROS_SVH
`define GROUPED_FREE_BLOCK_ALLOCATOR_MACROS_SVH

// Checked only while the block is out of reset.
`define GFBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define GFBA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/gfba_pkg.sv -----
package gfba_pkg;

    localparam int GROUP_LEN  = 16;
    localparam int NUM_BLOCKS = 256;
    localparam int ID_W       = 8;
    localparam int STORE_ROWS = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;

    localparam int ROW_W   = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
    localparam int IDX_W   = $clog2(GROUP_LEN);
    localparam int COUNT_W = $clog2(GROUP_LEN + 1);
    localparam int ADDR_W  = ROW_W + IDX_W;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    typedef struct packed {
        logic            req_type;
        logic [ID_W-1:0] block_id;
    } t_in_item;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] granted_id;
    } t_out_item;

    // Datapath condition flags seen by the controller.
    typedef struct packed {
        logic full;
        logic one;
        logic top_zero;
        logic id_ok;
        logic top_ok;
        logic sweep_last;
    } t_dp_stat;

    // Controller commands to the datapath.
    typedef struct packed {
        logic    push;
        logic    pop;
        logic    spill_start;
        logic    fill_start;
        logic    spill_step;
        logic    fill_step;
        logic    spill_end;
        logic    load_out;
        t_status res_status;
        logic    res_grant;
    } t_dp_cmd;

endpackage

// ----- hdl/gfba_dp.sv -----
module gfba_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gfba_pkg::t_in_item  i_item,
    input  gfba_pkg::t_dp_cmd   i_cmd,
    output gfba_pkg::t_dp_stat  o_stat,
    output gfba_pkg::t_out_item o_out
);
    import gfba_pkg::*;

    logic [ID_W-1:0]    r_stack [GROUP_LEN];
    logic [COUNT_W-1:0] r_count;
    logic [IDX_W-1:0]   r_idx;
    logic [ROW_W-1:0]   r_row;
    logic               r_rd_en;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [ID_W-1:0]    r_rd_data;
    t_out_item          r_out;

    logic [ID_W-1:0]    mem [2**ADDR_W];

    logic [IDX_W-1:0]   top_idx;
    logic [ID_W-1:0]    top;
    logic [ADDR_W-1:0]  addr;

    assign top_idx = IDX_W'(r_count - 1'b1);
    assign top     = r_stack[top_idx];
    assign addr    = {r_row, r_idx};

    assign o_stat.full       = (r_count == COUNT_W'(GROUP_LEN));
    assign o_stat.one        = (r_count == COUNT_W'(1));
    assign o_stat.top_zero   = (top == '0);
    assign o_stat.id_ok      = (32'(i_item.block_id) < STORE_ROWS);
    assign o_stat.top_ok     = (32'(top) < STORE_ROWS);
    assign o_stat.sweep_last = (r_idx == IDX_W'(GROUP_LEN - 1));
    assign o_out             = r_out;

    // Group store: one port, written during a spill, read during a refill.
    always_ff @(posedge i_clk) begin
        if (i_cmd.spill_step) begin
            mem[addr] <= r_stack[r_idx];
        end
        r_rd_data <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_en <= 1'b0;
        end else begin
            r_rd_en <= i_cmd.fill_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (i_cmd.spill_start) begin
            r_row <= ROW_W'(i_item.block_id);
        end else if (i_cmd.fill_start) begin
            r_row <= ROW_W'(top);
        end
        if (i_cmd.spill_start || i_cmd.fill_start) begin
            r_idx <= '0;
        end else if (i_cmd.spill_step || i_cmd.fill_step) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out.status     <= i_cmd.res_status;
            r_out.granted_id <= i_cmd.res_grant ? top : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < GROUP_LEN; i++) begin
                r_stack[i] <= '0;
            end
            r_count <= COUNT_W'(1);
        end else begin
            if (i_cmd.push) begin
                r_stack[IDX_W'(r_count)] <= i_item.block_id;
                r_count                  <= r_count + 1'b1;
            end
            if (i_cmd.pop) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.fill_start) begin
                r_count <= COUNT_W'(GROUP_LEN);
            end
            // The freed block whose row took the old stack becomes the only entry.
            if (i_cmd.spill_end) begin
                r_stack[0] <= ID_W'(r_row);
                r_count    <= COUNT_W'(1);
            end
            if (r_rd_en) begin
                r_stack[r_rd_idx] <= r_rd_data;
            end
        end
    end

endmodule

// ----- hdl/gfba_ctrl.sv -----
module gfba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_req_type,
    input  logic               i_out_ready,
    input  gfba_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output gfba_pkg::t_dp_cmd  o_cmd
);
    import gfba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SPILL = 4'b0010,
        S_FILL  = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = ST_OK;
        n_state          = r_state;
        n_out_valid      = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    if (i_req_type == REQ_FREE) begin
                        if (!i_stat.id_ok) begin
                            o_cmd.res_status = ST_RANGE;
                        end else if (i_stat.full) begin
                            o_cmd.spill_start = 1'b1;
                            n_state           = S_SPILL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end else begin
                        if (i_stat.top_zero) begin
                            o_cmd.res_status = ST_NOFREE;
                        end else if (i_stat.one) begin
                            if (!i_stat.top_ok) begin
                                o_cmd.res_status = ST_RANGE;
                            end else begin
                                o_cmd.res_grant  = 1'b1;
                                o_cmd.fill_start = 1'b1;
                                n_state          = S_FILL;
                            end
                        end else begin
                            o_cmd.res_grant = 1'b1;
                            o_cmd.pop       = 1'b1;
                        end
                    end
                end
            end
            S_SPILL: begin
                o_cmd.spill_step = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.spill_end = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last word read from the group store lands in the stack here.
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- hdl/grouped_free_block_allocator.sv -----
// Channel   Handshake                  Word
// request   i_in_valid / o_in_ready    i_in_data  (req_type, block_id)
// result    o_out_valid / i_out_ready  o_out_data (status, granted_id)
//
// Every request's result is registered at acceptance, valid in the next cycle.
// A free onto a full stack spills the stack into the group store, one word per
// cycle over the single memory port, before the next request is taken.
// A pop of the last entry refills the stack from the group store first.
// A request is taken only when the result register is empty or being emptied.
// Reset restores the stack to the empty marker; the group store is not cleared.
module grouped_free_block_allocator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gfba_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gfba_pkg::t_out_item o_out_data
);
    import gfba_pkg::*;

    t_dp_stat stat;
    t_dp_cmd  cmd;

    gfba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in_data.req_type),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    gfba_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_out   (o_out_data)
    );

endmodule

// ----- hdl/gfba_checker.sv -----
`include "grouped_free_block_allocator_macros.svh"

module gfba_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input gfba_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input gfba_pkg::t_out_item o_out_data
);
    import gfba_pkg::*;

    `GFBA_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result word changed while stalled")
    `GFBA_ASSERT(a_fail_no_grant, o_out_valid && (o_out_data.status != ST_OK) |-> (o_out_data.granted_id == '0), "failed request carries a granted id")
    `GFBA_ASSERT(a_result_follows, i_in_valid && o_in_ready |=> o_out_valid, "accepted request produced no result")
    `GFBA_ASSERT(a_free_ok, i_in_valid && o_in_ready && (i_in_data.req_type == REQ_FREE) && (32'(i_in_data.block_id) < STORE_ROWS) |=> (o_out_data.status == ST_OK) && (o_out_data.granted_id == '0), "in-range free not reported ok")
    `GFBA_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind grouped_free_block_allocator gfba_checker u_gfba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
